@@ design/clab_pkg.sv @@
// Shared types and constants for the clipped alpha blend area block.
// No dependencies; every other design file depends on this package.
package clab_pkg;

    // Field widths fixed by the pixel and index formats.
    localparam int PIX_W   = 32;
    localparam int RGB_W   = 24;
    localparam int IDX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int DIM_W   = 13;
    localparam int OFS_W   = 12;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd5;

    // Clipped area geometry, derived from the configuration registers.
    typedef struct packed {
        logic [DIM_W-1:0] front_width;   // clamped front width
        logic [DIM_W-1:0] back_width;    // clamped back width
        logic [DIM_W-1:0] area_width;    // clipped area width
        logic [DIM_W-1:0] area_height;   // clipped area height
        logic             empty;         // clipped area holds no pixels
    } t_area;

endpackage

@@ design/clab_if.sv @@
// Handshake channel interfaces for the pixel pair input and the result output.
// Depends on clab_pkg for the payload widths.
interface clab_pix_if;
    logic                       valid;
    logic                       ready;
    logic [clab_pkg::PIX_W-1:0] front_pixel;
    logic [clab_pkg::PIX_W-1:0] back_pixel;

    modport source (output valid, output front_pixel, output back_pixel, input ready);
    modport sink   (input valid, input front_pixel, input back_pixel, output ready);
endinterface

interface clab_res_if;
    logic                       valid;
    logic                       ready;
    logic [clab_pkg::RGB_W-1:0] blended_pixel;
    logic [clab_pkg::IDX_W-1:0] back_index;
    logic [clab_pkg::IDX_W-1:0] front_index;
    logic                       last_of_area;
    logic                       area_empty;

    modport source (output valid, output blended_pixel, output back_index,
                    output front_index, output last_of_area, output area_empty,
                    input ready);
    modport sink   (input valid, input blended_pixel, input back_index,
                    input front_index, input last_of_area, input area_empty,
                    output ready);
endinterface

@@ design/clab_area.sv @@
// Clamps the image dimensions and clips the front image to the back image.
// Depends on clab_pkg for the area structure and field widths.
module clab_area #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic [clab_pkg::DIM_W-1:0] i_front_width,
    input  logic [clab_pkg::DIM_W-1:0] i_front_height,
    input  logic [clab_pkg::DIM_W-1:0] i_back_width,
    input  logic [clab_pkg::DIM_W-1:0] i_back_height,
    input  logic [clab_pkg::OFS_W-1:0] i_offset_x,
    input  logic [clab_pkg::OFS_W-1:0] i_offset_y,
    output clab_pkg::t_area            o_area
);
    import clab_pkg::*;

    // Wide enough to compare against the limit and to hold dimension plus offset.
    localparam int W = DIM_W + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [W-1:0] lim;
        lim = W'(MAX_DIMENSION);
        return ({1'b0, v} > lim) ? lim[DIM_W-1:0] : v;
    endfunction

    logic [DIM_W-1:0] fw, fh, bw, bh;
    logic [DIM_W-1:0] aw, ah;

    always_comb begin
        fw = clamp_dim(i_front_width);
        fh = clamp_dim(i_front_height);
        bw = clamp_dim(i_back_width);
        bh = clamp_dim(i_back_height);

        // Where the front image runs past the back image's edge, keep only the overlap.
        aw = (W'(fw) + W'(i_offset_x) > W'(bw)) ? bw - DIM_W'(i_offset_x) : fw;
        ah = (W'(fh) + W'(i_offset_y) > W'(bh)) ? bh - DIM_W'(i_offset_y) : fh;

        o_area.front_width = fw;
        o_area.back_width  = bw;
        o_area.area_width  = aw;
        o_area.area_height = ah;
        o_area.empty       = (W'(i_offset_x) >= W'(bw)) || (W'(i_offset_y) >= W'(bh))
                             || (aw == '0) || (ah == '0);
    end

endmodule

@@ design/clab_blend.sv @@
// Per-channel alpha blend of a front ARGB pixel over a back ARGB pixel.
// Depends on clab_pkg for the pixel widths.
module clab_blend (
    input  logic [clab_pkg::PIX_W-1:0] i_front_pixel,
    input  logic [clab_pkg::PIX_W-1:0] i_back_pixel,
    output logic [clab_pkg::RGB_W-1:0] o_rgb
);
    import clab_pkg::*;

    localparam int NCHAN = RGB_W / CHAN_W;

    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] inv_alpha;

    assign alpha     = i_front_pixel[PIX_W-1 -: CHAN_W];
    assign inv_alpha = ~alpha;   // 255 - alpha

    for (genvar c = 0; c < NCHAN; c++) begin : g_chan
        logic [2*CHAN_W-1:0] f_term;
        logic [2*CHAN_W-1:0] b_term;
        logic [CHAN_W:0]     sum;

        assign f_term = i_front_pixel[c*CHAN_W +: CHAN_W] * alpha;
        assign b_term = i_back_pixel[c*CHAN_W +: CHAN_W] * inv_alpha;
        // Each term is truncated on its own; the sum stays below 255.
        assign sum    = (CHAN_W+1)'(f_term[2*CHAN_W-1:CHAN_W])
                      + (CHAN_W+1)'(b_term[2*CHAN_W-1:CHAN_W]);
        assign o_rgb[c*CHAN_W +: CHAN_W] = sum[CHAN_W-1:0];
    end

endmodule

@@ design/clipped_alpha_blend_area.sv @@
// Clipped alpha blend area. The block blends a front ARGB8888 image, placed at
// (offset_x, offset_y), over a back image and clipped to it. Pixel pairs arrive
// in raster order of the clipped area, one word per cycle at most, and each word
// gives exactly one result word: the blended RGB (alpha byte dropped), the back
// and front buffer indices of that pixel and a mark on the last pixel of the
// area. When the clipped area is empty every word instead gives a result with
// area_empty set and all other fields zero. The block is a two-register
// pipeline: an input register, set alongside the row and column counters, and
// a result register, which a word passes in that order on its way to the
// output; one word can be accepted every cycle while the output is taken.
// The counter update on acceptance is what allows a new word every cycle. Any
// write to a defined configuration register restarts the area at its first
// pixel; writes to undefined indexes are ignored. Dimensions above
// MAX_DIMENSION are treated as MAX_DIMENSION. Configuration must only be
// written while no word is in flight.
// Depends on clab_pkg, clab_if, clab_area and clab_blend.
module clipped_alpha_blend_area #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clab_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [clab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    clab_pix_if.sink                        i_pix,
    clab_res_if.source                      o_res
);
    import clab_pkg::*;

    // Counters only ever hold positions below the size of a non-empty area, itself at
    // most MAX_DIMENSION.
    localparam int CW      = $clog2(MAX_DIMENSION);
    localparam int SUM_W   = ((CW > OFS_W) ? CW : OFS_W) + 1;
    localparam int BPROD_W = SUM_W + DIM_W + 1;
    localparam int FPROD_W = CW + DIM_W + 1;

    // Configuration registers.
    logic [DIM_W-1:0] r_front_width, r_front_height, r_back_width, r_back_height;
    logic [OFS_W-1:0] r_offset_x, r_offset_y;
    logic             cfg_hit;

    // Position inside the clipped area.
    logic [CW-1:0] r_row, r_col;
    logic [CW-1:0] n_row, n_col;
    logic [CW-1:0] cur_row, cur_col;
    logic          n_last;

    // Input register stage.
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_front, r_a_back;
    logic [CW-1:0]    r_a_row, r_a_col;
    logic             r_a_last, r_a_empty;

    // Result register stage.
    logic             r_b_valid;
    logic [RGB_W-1:0] r_b_rgb;
    logic [IDX_W-1:0] r_b_bidx, r_b_fidx;
    logic             r_b_last, r_b_empty;

    logic in_acc, a_ready, b_ready, a_move;

    t_area            area;
    logic [RGB_W-1:0] blend_rgb;

    logic [SUM_W-1:0]   y_sum;
    logic [BPROD_W-1:0] b_full;
    logic [FPROD_W-1:0] f_full;
    logic [RGB_W-1:0]   n_b_rgb;
    logic [IDX_W-1:0]   n_b_bidx, n_b_fidx;

    clab_area #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_area (
        .i_front_width  (r_front_width),
        .i_front_height (r_front_height),
        .i_back_width   (r_back_width),
        .i_back_height  (r_back_height),
        .i_offset_x     (r_offset_x),
        .i_offset_y     (r_offset_y),
        .o_area         (area)
    );

    clab_blend u_blend (
        .i_front_pixel (r_a_front),
        .i_back_pixel  (r_a_back),
        .o_rgb         (blend_rgb)
    );

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_comb begin
        unique case (i_cfg_idx)
            REG_FRONT_WIDTH, REG_FRONT_HEIGHT, REG_BACK_WIDTH,
            REG_BACK_HEIGHT, REG_OFFSET_X, REG_OFFSET_Y: cfg_hit = 1'b1;
            default:                                     cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_width  <= '0;
            r_front_height <= '0;
            r_back_width   <= '0;
            r_back_height  <= '0;
            r_offset_x     <= '0;
            r_offset_y     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRONT_WIDTH:  r_front_width  <= i_cfg_data;
                REG_FRONT_HEIGHT: r_front_height <= i_cfg_data;
                REG_BACK_WIDTH:   r_back_width   <= i_cfg_data;
                REG_BACK_HEIGHT:  r_back_height  <= i_cfg_data;
                REG_OFFSET_X:     r_offset_x     <= i_cfg_data[OFS_W-1:0];
                REG_OFFSET_Y:     r_offset_y     <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the result register parts the two sides, and the input
    // register moves on whenever the result register is free or being taken.
    // ------------------------------------------------------------------
    assign b_ready     = !r_b_valid || o_res.ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign a_move      = r_a_valid && b_ready;
    assign in_acc      = i_pix.valid && a_ready;
    assign i_pix.ready = a_ready;

    // ------------------------------------------------------------------
    // Row and column counters. A position outside the area (which only a
    // stale state could give) restarts at the first pixel.
    // ------------------------------------------------------------------
    always_comb begin
        if ((DIM_W'(r_row) >= area.area_height) || (DIM_W'(r_col) >= area.area_width)) begin
            cur_row = '0;
            cur_col = '0;
        end else begin
            cur_row = r_row;
            cur_col = r_col;
        end

        n_last = (DIM_W'(cur_row) + DIM_W'(1) == area.area_height)
              && (DIM_W'(cur_col) + DIM_W'(1) == area.area_width);

        if (DIM_W'(cur_col) + DIM_W'(1) >= area.area_width) begin
            n_col = '0;
            n_row = (DIM_W'(cur_row) + DIM_W'(1) >= area.area_height) ? '0
                                                                       : cur_row + CW'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg_we && cfg_hit) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc && !area.empty) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // Input register stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_front <= i_pix.front_pixel;
            r_a_back  <= i_pix.back_pixel;
            r_a_row   <= cur_row;
            r_a_col   <= cur_col;
            r_a_last  <= n_last;
            r_a_empty <= area.empty;
        end
    end

    // ------------------------------------------------------------------
    // Blend and index arithmetic, then the result register. The user must keep
    // the configuration steady while words are in flight; the block does not enforce it.
    // ------------------------------------------------------------------
    always_comb begin
        y_sum  = SUM_W'(r_offset_y) + SUM_W'(r_a_row);
        b_full = BPROD_W'(y_sum) * BPROD_W'(area.back_width)
               + BPROD_W'(r_offset_x) + BPROD_W'(r_a_col);
        f_full = FPROD_W'(r_a_row) * FPROD_W'(area.front_width) + FPROD_W'(r_a_col);

        if (r_a_empty) begin
            n_b_rgb  = '0;
            n_b_bidx = '0;
            n_b_fidx = '0;
        end else begin
            n_b_rgb  = blend_rgb;
            n_b_bidx = IDX_W'(b_full);
            n_b_fidx = IDX_W'(f_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_rgb   <= n_b_rgb;
            r_b_bidx  <= n_b_bidx;
            r_b_fidx  <= n_b_fidx;
            r_b_last  <= r_a_last && !r_a_empty;
            r_b_empty <= r_a_empty;
        end
    end

    assign o_res.valid         = r_b_valid;
    assign o_res.blended_pixel = r_b_rgb;
    assign o_res.back_index    = r_b_bidx;
    assign o_res.front_index   = r_b_fidx;
    assign o_res.last_of_area  = r_b_last;
    assign o_res.area_empty    = r_b_empty;

`ifndef SYNTHESIS
    // The counters never point outside a non-empty area.
    a_counters_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !area.empty |-> DIM_W'(r_col) < area.area_width
                        && DIM_W'(r_row) < area.area_height)
        else $error("area counters outside the clipped area");

    // Accepting the last pixel of the area sends the counters back to the start.
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !area.empty && n_last) |=> (r_row == '0 && r_col == '0))
        else $error("counters did not wrap after the last pixel");

    // A full input stage behind a stalled result must hold off new words.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_b_valid && !o_res.ready) |-> !i_pix.ready)
        else $error("input accepted while the pipeline is full");

    // An empty-area result carries nothing but its flag.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.area_empty) |-> (o_res.blended_pixel == '0
            && o_res.back_index == '0 && o_res.front_index == '0 && !o_res.last_of_area))
        else $error("empty-area result with non-zero fields");
`endif

endmodule
